>>> sv/leb_pkg.sv
// Shared types and constants for the line edit buffer.
// Used by leb_ctrl, leb_datapath and line_edit_buffer_core; no dependencies.
package leb_pkg;

    localparam int KIND_W         = 3;
    localparam int CHAR_W         = 8;
    localparam int IDX_W          = 7;
    localparam int LINE_BYTES_DEF = 128;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT    = 3'd0,
        KIND_BACKSPACE = 3'd1,
        KIND_LEFT      = 3'd2,
        KIND_RIGHT     = 3'd3,
        KIND_HOME      = 3'd4,
        KIND_END       = 3'd5,
        KIND_CLEAR     = 3'd6,
        KIND_READ      = 3'd7
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SHIFT,
        ST_DRAIN,
        ST_WRCHAR,
        ST_COMMIT,
        ST_RESP
    } leb_state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic decode;
        logic shift;
        logic drain;
        logic write_char;
        logic commit_bs;
        logic rsp_load;
    } leb_ctrl_t;

    // datapath to controller
    typedef struct packed {
        logic ins_go;
        logic bs_go;
        logic shift_req;
        logic shift_last;
        logic rsp_free;
    } leb_stat_t;

endpackage

>>> sv/line_edit_buffer_core.sv
// Line edit buffer: a line store with cursor and length, one command per item.
// Command channel: cmd_valid/cmd_stall with kind, char_in, read_index.
// Response channel: rsp_valid/rsp_stall with ok, cursor_pos, line_length, read_byte.
// Exactly one response item per command item, in order.
// One command is worked at a time; cmd_stall is low only while the sequencer is idle.
// The next command can be taken in the cycle after the response is loaded.
// Cursor moves, clear and read go from decode straight to the response state.
// Backspace goes through decode, then shift and drain when a tail has to move, then commit and response.
// Insert goes through decode, then shift and drain when it lands inside the text, then char write and response.
// The shift moves one byte per cycle through the store's single write port.
// The response register holds a finished item while rsp_stall is high; the
// sequencer waits in its response state and takes no new command until it is free.
// Reset clears cursor, length and all handshake state. The store itself needs no
// clearing pass: bytes at or past the end of text read as zero, so the block is
// ready as soon as reset is released, and clear only resets cursor and length.
// Depends on leb_pkg, leb_ctrl and leb_datapath.
module line_edit_buffer_core #(
    parameter int LINE_BYTES = leb_pkg::LINE_BYTES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cmd_valid,
    output logic                        cmd_stall,
    input  logic [leb_pkg::KIND_W-1:0]  kind,
    input  logic [leb_pkg::CHAR_W-1:0]  char_in,
    input  logic [leb_pkg::IDX_W-1:0]   read_index,
    output logic                        rsp_valid,
    input  logic                        rsp_stall,
    output logic                        ok,
    output logic [leb_pkg::IDX_W-1:0]   cursor_pos,
    output logic [leb_pkg::IDX_W-1:0]   line_length,
    output logic [leb_pkg::CHAR_W-1:0]  read_byte
);
    import leb_pkg::*;

    leb_ctrl_t ctrl;
    leb_stat_t stat;

    leb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    leb_datapath #(
        .LINE_BYTES (LINE_BYTES)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .stat        (stat),
        .kind        (kind),
        .char_in     (char_in),
        .read_index  (read_index),
        .rsp_stall   (rsp_stall),
        .rsp_valid   (rsp_valid),
        .ok          (ok),
        .cursor_pos  (cursor_pos),
        .line_length (line_length),
        .read_byte   (read_byte)
    );

endmodule

>>> sv/leb_ctrl.sv
// Command sequencer for the line edit buffer.
// Depends on leb_pkg for the state enum and the command/status structs.
module leb_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  leb_pkg::leb_stat_t  stat,
    output leb_pkg::leb_ctrl_t  ctrl
);
    import leb_pkg::*;

    leb_state_t state_reg;
    leb_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (stat.shift_req)
                begin
                    state_next = ST_SHIFT;
                end
                else if (stat.ins_go)
                begin
                    state_next = ST_WRCHAR;
                end
                else if (stat.bs_go)
                begin
                    state_next = ST_COMMIT;
                end
                else
                begin
                    state_next = ST_RESP;
                end
            end
            ST_SHIFT:
            begin
                if (stat.shift_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = stat.ins_go ? ST_WRCHAR : ST_COMMIT;
            end
            ST_WRCHAR:
            begin
                state_next = ST_RESP;
            end
            ST_COMMIT:
            begin
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (stat.rsp_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctrl      = '0;
        cmd_stall = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                cmd_stall = 1'b0;
                ctrl.load = cmd_valid;
            end
            ST_DECODE:
            begin
                ctrl.decode = 1'b1;
            end
            ST_SHIFT:
            begin
                ctrl.shift = 1'b1;
            end
            ST_DRAIN:
            begin
                ctrl.drain = 1'b1;
            end
            ST_WRCHAR:
            begin
                ctrl.write_char = 1'b1;
            end
            ST_COMMIT:
            begin
                ctrl.commit_bs = 1'b1;
            end
            ST_RESP:
            begin
                ctrl.rsp_load = stat.rsp_free;
            end
            default:
            begin
                ctrl = '0;
            end
        endcase
    end

endmodule

>>> sv/leb_datapath.sv
// Line store, cursor and length registers, shift pointer and result register.
// Depends on leb_pkg; driven by leb_ctrl through leb_ctrl_t / leb_stat_t.
module leb_datapath #(
    parameter int LINE_BYTES = leb_pkg::LINE_BYTES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  leb_pkg::leb_ctrl_t          ctrl,
    output leb_pkg::leb_stat_t          stat,
    input  logic [leb_pkg::KIND_W-1:0]  kind,
    input  logic [leb_pkg::CHAR_W-1:0]  char_in,
    input  logic [leb_pkg::IDX_W-1:0]   read_index,
    input  logic                        rsp_stall,
    output logic                        rsp_valid,
    output logic                        ok,
    output logic [leb_pkg::IDX_W-1:0]   cursor_pos,
    output logic [leb_pkg::IDX_W-1:0]   line_length,
    output logic [leb_pkg::CHAR_W-1:0]  read_byte
);
    import leb_pkg::*;

    localparam int AW = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1;
    localparam logic [AW-1:0] LAST_SLOT = AW'(LINE_BYTES - 1);

    logic [CHAR_W-1:0] mem [LINE_BYTES];

    kind_t             kind_reg;
    logic [CHAR_W-1:0] char_reg;
    logic [IDX_W-1:0]  ridx_reg;

    logic [AW-1:0]     cursor_reg, cursor_next;
    logic [AW-1:0]     len_reg, len_next;
    logic [AW-1:0]     ptr_reg, ptr_next;
    logic [AW-1:0]     wr_addr_reg;
    logic              wr_pend_reg, wr_pend_next;
    logic [CHAR_W-1:0] rdata_reg;
    logic              ok_res_reg, read_hit_reg;

    logic              rsp_valid_reg, rsp_valid_next;
    logic              ok_out_reg;
    logic [IDX_W-1:0]  cursor_out_reg, len_out_reg;
    logic [CHAR_W-1:0] byte_out_reg;

    logic              in_text, is_ins, ins_go, bs_go, read_ok, read_hit, ok_calc;
    logic              mem_we, mem_re;
    logic [AW-1:0]     mem_waddr, mem_raddr;
    logic [CHAR_W-1:0] mem_wdata;

    // command checks, all from state before the command takes effect
    always_comb
    begin
        in_text  = cursor_reg < len_reg;
        is_ins   = kind_reg == KIND_INSERT;
        ins_go   = is_ins && (char_reg != '0) && (cursor_reg != LAST_SLOT)
                   && !(in_text && (len_reg == LAST_SLOT));
        bs_go    = (kind_reg == KIND_BACKSPACE) && (cursor_reg != '0);
        read_ok  = 32'(ridx_reg) < 32'(LINE_BYTES);
        // reads at or past the end of text always return a zero byte
        read_hit = (kind_reg == KIND_READ) && (32'(ridx_reg) < 32'(len_reg));
        case (kind_reg)
            KIND_INSERT:    ok_calc = ins_go;
            KIND_BACKSPACE: ok_calc = bs_go;
            KIND_LEFT:      ok_calc = cursor_reg != '0;
            KIND_RIGHT:     ok_calc = in_text;
            KIND_HOME:      ok_calc = 1'b1;
            KIND_END:       ok_calc = 1'b1;
            KIND_CLEAR:     ok_calc = 1'b1;
            KIND_READ:      ok_calc = read_ok;
            default:        ok_calc = 1'b0;
        endcase
    end

    always_comb
    begin
        stat.ins_go     = ins_go;
        stat.bs_go      = bs_go;
        stat.shift_req  = (ins_go || bs_go) && in_text;
        stat.shift_last = is_ins ? (ptr_reg == cursor_reg)
                                 : (ptr_reg == (len_reg - AW'(1)));
        stat.rsp_free   = !rsp_valid_reg || !rsp_stall;
    end

    always_comb
    begin
        cursor_next  = cursor_reg;
        len_next     = len_reg;
        ptr_next     = ptr_reg;
        wr_pend_next = wr_pend_reg;
        if (ctrl.decode)
        begin
            // insert walks down from the last char, backspace up from the cursor
            ptr_next     = is_ins ? (len_reg - AW'(1)) : cursor_reg;
            wr_pend_next = 1'b0;
            case (kind_reg)
                KIND_LEFT:
                begin
                    if (cursor_reg != '0)
                    begin
                        cursor_next = cursor_reg - AW'(1);
                    end
                end
                KIND_RIGHT:
                begin
                    if (in_text)
                    begin
                        cursor_next = cursor_reg + AW'(1);
                    end
                end
                KIND_HOME:
                begin
                    cursor_next = '0;
                end
                KIND_END:
                begin
                    cursor_next = len_reg;
                end
                KIND_CLEAR:
                begin
                    cursor_next = '0;
                    len_next    = '0;
                end
                default:
                begin
                    cursor_next = cursor_reg;
                end
            endcase
        end
        if (ctrl.shift)
        begin
            ptr_next     = is_ins ? (ptr_reg - AW'(1)) : (ptr_reg + AW'(1));
            wr_pend_next = 1'b1;
        end
        if (ctrl.drain)
        begin
            wr_pend_next = 1'b0;
        end
        if (ctrl.write_char)
        begin
            cursor_next = cursor_reg + AW'(1);
            len_next    = len_reg + AW'(1);
        end
        if (ctrl.commit_bs)
        begin
            cursor_next = cursor_reg - AW'(1);
            len_next    = len_reg - AW'(1);
        end
    end

    // write one place behind the read: data read last cycle lands next to its source
    always_comb
    begin
        mem_we    = ((ctrl.shift || ctrl.drain) && wr_pend_reg) || ctrl.write_char;
        mem_waddr = ctrl.write_char ? cursor_reg : wr_addr_reg;
        mem_wdata = ctrl.write_char ? char_reg : rdata_reg;
        mem_re    = ctrl.shift || (ctrl.decode && read_hit);
        mem_raddr = ctrl.shift ? ptr_reg : AW'(ridx_reg);
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (ctrl.rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg    <= '0;
            len_reg       <= '0;
            wr_pend_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            cursor_reg    <= cursor_next;
            len_reg       <= len_next;
            wr_pend_reg   <= wr_pend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg <= ptr_next;
        if (ctrl.load)
        begin
            kind_reg <= kind_t'(kind);
            char_reg <= char_in;
            ridx_reg <= read_index;
        end
        if (ctrl.decode)
        begin
            ok_res_reg   <= ok_calc;
            read_hit_reg <= read_hit;
        end
        if (ctrl.shift)
        begin
            wr_addr_reg <= is_ins ? (ptr_reg + AW'(1)) : (ptr_reg - AW'(1));
        end
        if (ctrl.rsp_load)
        begin
            ok_out_reg     <= ok_res_reg;
            cursor_out_reg <= IDX_W'(cursor_reg);
            len_out_reg    <= IDX_W'(len_reg);
            byte_out_reg   <= read_hit_reg ? rdata_reg : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    assign rsp_valid   = rsp_valid_reg;
    assign ok          = ok_out_reg;
    assign cursor_pos  = cursor_out_reg;
    assign line_length = len_out_reg;
    assign read_byte   = byte_out_reg;

endmodule

>>> tb/line_edit_buffer_core_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for line_edit_buffer_core: random edit commands with idling and stalls,
// checked against a line store, cursor and length tracked in the bench. Depends on leb_pkg.
module line_edit_buffer_core_tb;

    import leb_pkg::*;

    localparam int LINE_BYTES     = LINE_BYTES_DEF;
    localparam int LONG_HOLD      = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 200;

    typedef struct {
        kind_t              kind;
        logic [CHAR_W-1:0]  ch;
        logic [IDX_W-1:0]   idx;
    } edit_cmd_t;

    typedef struct packed {
        logic               ok;
        logic [IDX_W-1:0]   cursor;
        logic [IDX_W-1:0]   length;
        logic [CHAR_W-1:0]  rdata;
    } edit_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cmd_valid = 1'b0;
    logic               cmd_stall;
    kind_t              kind = KIND_READ;
    logic [CHAR_W-1:0]  char_in = '0;
    logic [IDX_W-1:0]   read_index = '0;
    logic               rsp_valid;
    logic               rsp_stall = 1'b0;
    logic               ok;
    logic [IDX_W-1:0]   cursor_pos;
    logic [IDX_W-1:0]   line_length;
    logic [CHAR_W-1:0]  read_byte;

    // tracked line state
    logic [CHAR_W-1:0]  line_mem [LINE_BYTES];
    logic [IDX_W-1:0]   cur_pos;
    logic [IDX_W-1:0]   txt_len;

    edit_cmd_t          cmd_queue [$];
    edit_result_t       pending_results [$];
    edit_cmd_t          next_cmd;
    edit_result_t       want;
    bit                 cmd_taken;
    bit                 quiet = 1'b0;
    int                 hold_requests = 0;
    int                 holds_done = 0;
    int                 hold_left = 0;
    int                 snd_gap = 0;
    int                 snd_pct = 0;
    int                 snd_mode_cnt = 0;
    int                 rcv_gap = 0;
    int                 rcv_pct = 0;
    int                 rcv_mode_cnt = 0;
    int                 mismatch_cnt = 0;
    int                 rsp_count = 0;
    int                 issued = 0;
    int                 idle_cycles = 0;

    line_edit_buffer_core #(
        .LINE_BYTES (LINE_BYTES)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_stall   (cmd_stall),
        .kind        (kind),
        .char_in     (char_in),
        .read_index  (read_index),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .ok          (ok),
        .cursor_pos  (cursor_pos),
        .line_length (line_length),
        .read_byte   (read_byte)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Apply one command to the tracked line and return the response it should give.
    function automatic edit_result_t edit_line(kind_t op, logic [CHAR_W-1:0] ch,
                                               logic [IDX_W-1:0] idx);
        edit_result_t r;
        int i;
        r = '0;
        case (op)
            KIND_INSERT:
            begin
                // refuse a zero byte, the last slot, and a mid-line insert into a full line
                if (ch != '0 && int'(cur_pos) < LINE_BYTES - 1 &&
                    !(cur_pos < txt_len && int'(txt_len) > LINE_BYTES - 2))
                begin
                    for (i = int'(txt_len); i > int'(cur_pos); i--)
                        line_mem[i] = line_mem[i - 1];
                    if (int'(txt_len) < LINE_BYTES - 1)
                    begin
                        txt_len++;
                        line_mem[txt_len] = '0;
                    end
                    line_mem[cur_pos] = ch;
                    cur_pos++;
                    r.ok = 1'b1;
                end
            end
            KIND_BACKSPACE:
            begin
                if (cur_pos != '0 && txt_len != '0)
                begin
                    cur_pos--;
                    for (i = int'(cur_pos); i + 1 < int'(txt_len); i++)
                        line_mem[i] = line_mem[i + 1];
                    txt_len--;
                    line_mem[txt_len] = '0;
                    r.ok = 1'b1;
                end
            end
            KIND_LEFT:
            begin
                if (cur_pos != '0)
                begin
                    cur_pos--;
                    r.ok = 1'b1;
                end
            end
            KIND_RIGHT:
            begin
                if (cur_pos < txt_len)
                begin
                    cur_pos++;
                    r.ok = 1'b1;
                end
            end
            KIND_HOME:
            begin
                cur_pos = '0;
                r.ok = 1'b1;
            end
            KIND_END:
            begin
                cur_pos = txt_len;
                r.ok = 1'b1;
            end
            KIND_CLEAR:
            begin
                foreach (line_mem[j])
                    line_mem[j] = '0;
                cur_pos = '0;
                txt_len = '0;
                r.ok = 1'b1;
            end
            default:
            begin
                if (int'(idx) < LINE_BYTES)
                begin
                    r.rdata = line_mem[idx];
                    r.ok = 1'b1;
                end
            end
        endcase
        r.cursor = cur_pos;
        r.length = txt_len;
        return r;
    endfunction

    function automatic int pick_idle_pct();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 10;
            default: return 35;
        endcase
    endfunction

    function automatic logic [CHAR_W-1:0] rnd_char();
        if ($urandom_range(0, 15) == 0)
            return '0;
        return CHAR_W'($urandom_range(1, 255));
    endfunction

    function automatic logic [IDX_W-1:0] rnd_idx();
        return IDX_W'($urandom_range(0, LINE_BYTES - 1));
    endfunction

    function automatic kind_t rnd_edit_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30)
            return KIND_INSERT;
        if (r < 50)
            return KIND_BACKSPACE;
        if (r < 62)
            return KIND_LEFT;
        if (r < 74)
            return KIND_RIGHT;
        if (r < 79)
            return KIND_HOME;
        if (r < 84)
            return KIND_END;
        if (r < 86)
            return KIND_CLEAR;
        return KIND_READ;
    endfunction

    task automatic push_cmd(kind_t op, logic [CHAR_W-1:0] ch, logic [IDX_W-1:0] idx);
        edit_cmd_t c;
        // keep the queue short so phase changes take effect promptly
        while (cmd_queue.size() >= 8)
            @(negedge clk);
        c.kind = op;
        c.ch   = ch;
        c.idx  = idx;
        cmd_queue.push_back(c);
        issued++;
    endtask

    task automatic wait_drained();
        while (cmd_queue.size() != 0 || cmd_valid || pending_results.size() != 0)
            @(negedge clk);
    endtask

    // One editing sequence; sel picks its flavor.
    task automatic run_episode(int sel);
        int n;
        if (sel < 25)
        begin
            // typing burst
            n = $urandom_range(1, 24);
            repeat (n)
                push_cmd(KIND_INSERT, rnd_char(), rnd_idx());
        end
        else if (sel < 60)
        begin
            n = $urandom_range(4, 24);
            repeat (n)
                push_cmd(rnd_edit_kind(), rnd_char(), rnd_idx());
        end
        else if (sel < 68)
        begin
            // fill the line to the last slot, then edit inside the full line
            if ($urandom_range(0, 1))
                push_cmd(KIND_CLEAR, rnd_char(), rnd_idx());
            push_cmd(KIND_END, rnd_char(), rnd_idx());
            n = $urandom_range(LINE_BYTES - 1, LINE_BYTES + 4);
            repeat (n)
                push_cmd(KIND_INSERT, CHAR_W'($urandom_range(1, 255)), rnd_idx());
            if ($urandom_range(0, 1))
                push_cmd(KIND_HOME, rnd_char(), rnd_idx());
            else
                repeat ($urandom_range(1, 6))
                    push_cmd(KIND_LEFT, rnd_char(), rnd_idx());
            repeat (2)
                push_cmd(KIND_INSERT, CHAR_W'($urandom_range(1, 255)), rnd_idx());
            push_cmd(KIND_BACKSPACE, rnd_char(), rnd_idx());
            repeat (2)
                push_cmd(KIND_INSERT, CHAR_W'($urandom_range(1, 255)), rnd_idx());
            repeat (3)
                push_cmd(KIND_READ, rnd_char(), rnd_idx());
        end
        else if (sel < 80)
        begin
            n = $urandom_range(2, 16);
            repeat (n)
                push_cmd(kind_t'($urandom_range(KIND_LEFT, KIND_END)), rnd_char(), rnd_idx());
            repeat ($urandom_range(1, 8))
                push_cmd(KIND_READ, rnd_char(), rnd_idx());
        end
        else if (sel < 92)
        begin
            // noise: any command, any byte
            n = $urandom_range(1, 16);
            repeat (n)
                push_cmd(kind_t'($urandom_range(0, 7)), CHAR_W'($urandom_range(0, 255)),
                         rnd_idx());
        end
        else
        begin
            push_cmd(KIND_CLEAR, rnd_char(), rnd_idx());
            repeat ($urandom_range(1, 4))
                push_cmd(KIND_READ, rnd_char(), rnd_idx());
        end
    endtask

    // command driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid  <= 1'b0;
            kind       <= KIND_READ;
            char_in    <= '0;
            read_index <= '0;
            foreach (line_mem[j])
                line_mem[j] = '0;
            cur_pos = '0;
            txt_len = '0;
        end
        else
        begin
            cmd_taken = cmd_valid && !cmd_stall;
            if (cmd_taken)
                pending_results.push_back(edit_line(kind, char_in, read_index));
            if (snd_mode_cnt == 0)
            begin
                snd_mode_cnt = $urandom_range(50, 300);
                snd_pct = pick_idle_pct();
            end
            else
                snd_mode_cnt--;
            // hold the payload until taken
            if (!cmd_valid || cmd_taken)
            begin
                if (cmd_taken && !quiet && $urandom_range(0, 99) < snd_pct)
                    snd_gap = $urandom_range(1, 7);
                if (snd_gap > 0)
                begin
                    snd_gap--;
                    cmd_valid <= 1'b0;
                end
                else if (cmd_queue.size() != 0)
                begin
                    next_cmd = cmd_queue.pop_front();
                    cmd_valid  <= 1'b1;
                    kind       <= next_cmd.kind;
                    char_in    <= next_cmd.ch;
                    read_index <= next_cmd.idx;
                end
                else
                    cmd_valid <= 1'b0;
            end
        end
    end

    // response monitor and stall generator
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_stall <= 1'b0;
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                rsp_count++;
                if (pending_results.size() == 0)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("response %0d with no command pending: ok=%0d cursor=%0d length=%0d byte=%02h",
                                 rsp_count, ok, cursor_pos, line_length, read_byte);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (ok !== want.ok || cursor_pos !== want.cursor ||
                        line_length !== want.length || read_byte !== want.rdata)
                    begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                            $display("response %0d: expected ok=%0d cursor=%0d length=%0d byte=%02h, got ok=%0d cursor=%0d length=%0d byte=%02h",
                                     rsp_count, want.ok, want.cursor, want.length, want.rdata,
                                     ok, cursor_pos, line_length, read_byte);
                    end
                end
            end
            if (rcv_mode_cnt == 0)
            begin
                rcv_mode_cnt = $urandom_range(50, 300);
                rcv_pct = pick_idle_pct();
            end
            else
                rcv_mode_cnt--;
            if (holds_done != hold_requests)
            begin
                holds_done++;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else if (rcv_gap > 0)
            begin
                rcv_gap--;
                rsp_stall <= 1'b1;
            end
            else if (!rsp_stall && !quiet && $urandom_range(0, 99) < rcv_pct)
            begin
                rcv_gap = $urandom_range(1, 7) - 1;
                rsp_stall <= 1'b1;
            end
            else
                rsp_stall <= 1'b0;
        end
    end

    // end the run if nothing moves on either channel for too long
    always @(posedge clk)
    begin
        if (rst_n && !((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall)))
            idle_cycles++;
        else
            idle_cycles = 0;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty line: refusals at the start, then a short edit session
        push_cmd(KIND_READ,      8'h00, 7'd0);
        push_cmd(KIND_BACKSPACE, 8'h00, 7'd0);
        push_cmd(KIND_LEFT,      8'h00, 7'd0);
        push_cmd(KIND_RIGHT,     8'h00, 7'd0);
        push_cmd(KIND_INSERT,    8'h00, 7'd0);
        push_cmd(KIND_INSERT,    8'hFF, 7'h7F);
        push_cmd(KIND_INSERT,    8'h01, 7'd0);
        push_cmd(KIND_INSERT,    8'h80, 7'd0);
        push_cmd(KIND_LEFT,      8'h00, 7'd0);
        push_cmd(KIND_INSERT,    8'h55, 7'd0);
        push_cmd(KIND_HOME,      8'h00, 7'd0);
        push_cmd(KIND_BACKSPACE, 8'h00, 7'd0);
        push_cmd(KIND_RIGHT,     8'h00, 7'd0);
        push_cmd(KIND_INSERT,    8'hAA, 7'd0);
        push_cmd(KIND_END,       8'h00, 7'd0);
        push_cmd(KIND_BACKSPACE, 8'h00, 7'd0);
        push_cmd(KIND_READ,      8'h00, 7'd0);
        push_cmd(KIND_READ,      8'h00, 7'd1);
        push_cmd(KIND_READ,      8'h00, 7'd3);
        push_cmd(KIND_READ,      8'h00, 7'h40);
        push_cmd(KIND_READ,      8'h00, 7'h7F);
        push_cmd(KIND_CLEAR,     8'h00, 7'd0);
        push_cmd(KIND_READ,      8'h00, 7'd0);
        push_cmd(KIND_END,       8'h00, 7'd0);
        wait_drained();

        // long receiver hold while commands keep coming
        hold_requests++;
        repeat (20)
            push_cmd(rnd_edit_kind(), rnd_char(), rnd_idx());
        run_episode(60);
        while (issued < 900)
            run_episode($urandom_range(0, 99));

        wait_drained();
        hold_requests++;
        while (issued < 1400)
            run_episode($urandom_range(0, 99));

        // no idling from here on
        quiet = 1'b1;
        while (issued < 1600)
            run_episode($urandom_range(0, 99));

        wait_drained();
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (mismatch_cnt == 0 && pending_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> filelist.f
sv/leb_pkg.sv
sv/leb_ctrl.sv
sv/leb_datapath.sv
sv/line_edit_buffer_core.sv
tb/line_edit_buffer_core_tb.sv
